FILE: rtl/core/polar_to_cartesian_gate_top_defines.svh
// Assertion macros shared by the polar-to-Cartesian gate RTL.
// Included by polar_to_cartesian_gate_top.sv; depends on nothing else.
`ifndef POLAR_TO_CARTESIAN_GATE_TOP_DEFINES_SVH
`define POLAR_TO_CARTESIAN_GATE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define P2CG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("p2cg same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define P2CG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("p2cg next-cycle check failed");

`endif

FILE: rtl/core/p2cg_pkg.sv
// Package for the polar-to-Cartesian gate: widths, CORDIC constants, types
// and the output rounding function. Depends on nothing.
`default_nettype none

package p2cg_pkg;

  localparam int RangeW     = 16;
  localparam int IdxW       = 12;
  localparam int AngW       = 32;
  localparam int OutW       = 17;
  localparam int MAX_BEAMS  = 4096;
  localparam int CordicIters = 24;
  localparam int FracW      = 30;
  localparam int GainW      = 30;
  localparam int MagW       = RangeW + GainW;
  localparam int XW         = 49;   // x/y datapath, Q30 millimetres with headroom
  localparam int ZW         = 34;   // residual angle with headroom
  localparam int InDataW    = 32;
  localparam int OutDataW   = 40;

  localparam logic [GainW-1:0] GainQ30 = 30'd652032874;
  localparam logic signed [XW-1:0] RndBias = XW'(64'd1 << (FracW - 1));
  localparam logic signed [XW-1:0] OutLimPos = XW'(65535);
  localparam logic signed [XW-1:0] OutLimNeg = -XW'(65535);

  localparam logic [AngW-1:0] AtanTab [CordicIters] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [1:0] {
    REG_MIN_RANGE   = 2'd0,
    REG_MAX_RANGE   = 2'd1,
    REG_START_ANGLE = 2'd2,
    REG_ANGLE_STEP  = 2'd3
  } p2cg_reg_t;

  // One word in flight through the rotator.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } p2cg_rot_t;

  // Round half up to whole millimetres, then clamp to +-65535.
  function automatic logic signed [OutW-1:0] p2cg_finish(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] sum;
    logic signed [XW-1:0] r;
    logic signed [XW-1:0] c;
    sum = v + RndBias;
    r   = sum >>> FracW;
    if (r > OutLimPos) begin
      c = OutLimPos;
    end else if (r < OutLimNeg) begin
      c = OutLimNeg;
    end else begin
      c = r;
    end
    return c[OutW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/p2cg_cordic.sv
// Rotation-mode CORDIC pipeline, one iteration per register stage.
// Depends on p2cg_pkg (widths, atan table, p2cg_rot_t).
`default_nettype none

module p2cg_cordic (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               ce,
  input  wire logic               in_vld,
  input  wire p2cg_pkg::p2cg_rot_t in_rot,
  output logic                    out_vld,
  output p2cg_pkg::p2cg_rot_t     out_rot
);
  import p2cg_pkg::*;

  p2cg_rot_t              stg_r [CordicIters];
  logic [CordicIters-1:0] vld_r;

  for (genvar i = 0; i < CordicIters; i++) begin : g_iter
    p2cg_rot_t            src;
    p2cg_rot_t            stg_nxt;
    logic                 src_vld;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] da;

    if (i == 0) begin : g_first
      assign src     = in_rot;
      assign src_vld = in_vld;
    end else begin : g_rest
      assign src     = stg_r[i-1];
      assign src_vld = vld_r[i-1];
    end

    always_comb begin
      dx = $signed(src.y) >>> i;
      dy = $signed(src.x) >>> i;
      da = $signed({{(ZW-AngW){1'b0}}, AtanTab[i]});
      stg_nxt      = src;
      if (!src.z[ZW-1]) begin
        stg_nxt.x = src.x - dx;
        stg_nxt.y = src.y + dy;
        stg_nxt.z = src.z - da;
      end else begin
        stg_nxt.x = src.x + dx;
        stg_nxt.y = src.y - dy;
        stg_nxt.z = src.z + da;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (ce) begin
        vld_r[i] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        stg_r[i] <= stg_nxt;
      end
    end
  end

  assign out_vld = vld_r[CordicIters-1];
  assign out_rot = stg_r[CordicIters-1];

endmodule

`default_nettype wire

FILE: rtl/core/polar_to_cartesian_gate_top.sv
// Top level of the polar-to-Cartesian gate: range window, beam angle, CORDIC
// rotator (p2cg_cordic), rounding and a two-entry output buffer. Uses p2cg_pkg.
`default_nettype none
`include "polar_to_cartesian_gate_top_defines.svh"

// Turns a lidar beam word (range in mm, beam index) into x/y in mm. A word
// whose range lies outside [min_range_mm, max_range_mm] is dropped and yields
// no output word; if the minimum exceeds the maximum every word is dropped.
// Beam angle = start_angle + beam_index * angle_step, a 32-bit binary angle
// (2^31 is pi) that wraps. The angle is folded into [-pi/2, pi/2), rotated by
// 24 CORDIC iterations in Q30 millimetres, negated back if folded, then
// rounded half up and saturated to +-65535. Throughput: one word per clock
// while the sink keeps up. Stages in order: one for the window check and
// the index*step multiply, one for the angle add, fold and range*gain
// multiply, 24 rotator stages (one iteration each), one for the sign
// restore, and the output register. The whole pipeline advances together
// on one enable; a second output slot absorbs the word still in flight
// when the sink stalls, so in_tready is a register and never depends
// combinationally on out_tready. Write configuration only while idle.
module polar_to_cartesian_gate_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input stream: [15:0] range_mm, [27:16] beam_index, [31:28] zero
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [p2cg_pkg::InDataW-1:0]  in_tdata,
  // output stream: [16:0] x_mm, [33:17] y_mm, [39:34] zero
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [p2cg_pkg::OutDataW-1:0]      out_tdata,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_addr,
  input  wire logic [p2cg_pkg::AngW-1:0]     cfg_wdata
);
  import p2cg_pkg::*;

  // configuration registers
  logic [RangeW-1:0] min_range_r;
  logic [RangeW-1:0] max_range_r;
  logic [AngW-1:0]   start_ang_r;
  logic [AngW-1:0]   ang_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r <= '0;
      max_range_r <= '1;
      start_ang_r <= '0;
      ang_step_r  <= '0;
    end else if (cfg_we) begin
      case (p2cg_reg_t'(cfg_addr))
        REG_MIN_RANGE:   min_range_r <= cfg_wdata[RangeW-1:0];
        REG_MAX_RANGE:   max_range_r <= cfg_wdata[RangeW-1:0];
        REG_START_ANGLE: start_ang_r <= cfg_wdata;
        REG_ANGLE_STEP:  ang_step_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline enable: advance everything unless the spare output slot is taken.
  logic skid_vld_r;
  logic ce;
  assign ce        = !skid_vld_r;
  assign in_tready = ce;

  // stage 0: window check and index * step
  logic [RangeW-1:0] in_range;
  logic [IdxW-1:0]   in_idx;
  logic              in_keep;
  logic              s0_vld_r;
  logic [RangeW-1:0] s0_range_r;
  logic [AngW-1:0]   s0_prod_r;
  logic [AngW-1:0]   prod_nxt;

  assign in_range = in_tdata[RangeW-1:0];
  assign in_idx   = in_tdata[RangeW +: IdxW];
  assign in_keep  = (in_range >= min_range_r) && (in_range <= max_range_r) &&
                    ({1'b0, in_idx} < (IdxW+1)'(MAX_BEAMS));
  assign prod_nxt = AngW'(in_idx) * ang_step_r;   // low 32 bits wrap as intended

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (ce) begin
      s0_vld_r <= in_tvalid && in_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s0_range_r <= in_range;
      s0_prod_r  <= prod_nxt;
    end
  end

  // stage 1: angle sum, fold into the right half plane, gain-scaled start vector
  logic [AngW-1:0]  ang_sum;
  logic             fold;
  logic [AngW-1:0]  ang_fold;
  logic [MagW-1:0]  mag;
  p2cg_rot_t        s1_nxt;
  p2cg_rot_t        s1_rot_r;
  logic             s1_vld_r;

  always_comb begin
    ang_sum  = start_ang_r + s0_prod_r;
    // second and third quadrant: add pi (toggle the top bit) and negate at the end
    fold     = ang_sum[AngW-1] ^ ang_sum[AngW-2];
    ang_fold = {ang_sum[AngW-1] ^ fold, ang_sum[AngW-2:0]};
    mag      = MagW'(s0_range_r) * MagW'(GainQ30);
    s1_nxt.x    = $signed({{(XW-MagW){1'b0}}, mag});
    s1_nxt.y    = '0;
    s1_nxt.z    = $signed({{(ZW-AngW){ang_fold[AngW-1]}}, ang_fold});
    s1_nxt.flip = fold;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (ce) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_rot_r <= s1_nxt;
    end
  end

  // rotator
  logic      rot_vld;
  p2cg_rot_t rot_out;

  p2cg_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .in_vld  (s1_vld_r),
    .in_rot  (s1_rot_r),
    .out_vld (rot_vld),
    .out_rot (rot_out)
  );

  // sign restore stage
  logic                 ng_vld_r;
  logic signed [XW-1:0] ng_x_r;
  logic signed [XW-1:0] ng_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ng_vld_r <= 1'b0;
    end else if (ce) begin
      ng_vld_r <= rot_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ng_x_r <= rot_out.flip ? -rot_out.x : rot_out.x;
      ng_y_r <= rot_out.flip ? -rot_out.y : rot_out.y;
    end
  end

  // round, saturate and pack the finished word
  logic [OutDataW-1:0] fin_data;
  logic                push;
  logic                pop;

  assign fin_data = {{(OutDataW-2*OutW){1'b0}}, p2cg_finish(ng_y_r), p2cg_finish(ng_x_r)};
  assign push     = ce && ng_vld_r;

  // two-entry output buffer: main register plus spare slot
  logic                out_vld_r;
  logic [OutDataW-1:0] out_data_r;
  logic [OutDataW-1:0] skid_data_r;

  assign pop = out_vld_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      // pipeline is held; drain the spare slot first
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_vld_r || pop) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!out_vld_r || pop) begin
        out_data_r <= fin_data;
      end else begin
        skid_data_r <= fin_data;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // the spare slot only fills behind a held main register
  `P2CG_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_vld_r, out_vld_r)
  // a word arriving at a stalled, full main register must land in the spare slot
  `P2CG_ASSERT_NEXT(a_push_to_skid, clk, rst_n,
                    push && out_vld_r && !out_tready, skid_vld_r)
  // while the pipeline is held its stage valids stay put
  `P2CG_ASSERT_NEXT(a_hold_on_stall, clk, rst_n,
                    !ce && $past(!ce), $stable(ng_vld_r) && $stable(s0_vld_r))

endmodule

`default_nettype wire

FILE: sim/p2cg_xy_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the polar-to-Cartesian gate: snoops the beam, result and
// register write ports, predicts x/y per accepted beam word and compares.
// Depends on p2cg_pkg for widths and register codes.

module p2cg_xy_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [p2cg_pkg::InDataW-1:0]      in_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [p2cg_pkg::OutDataW-1:0]     out_tdata,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_addr,
  input  logic [p2cg_pkg::AngW-1:0]         cfg_wdata,
  output int                                fail_count,
  output int                                xy_pending
);

  typedef struct {
    logic signed [16:0] x;
    logic signed [16:0] y;
  } xy_mm_t;

  localparam longint CordicGain = 64'sd652032874;   // CORDIC scale factor K (inverse of the gain) in Q30
  localparam longint RoundHalf  = 64'sd536870912;   // half a millimetre in Q30
  localparam longint MmLimit    = 64'sd65535;
  localparam int     RotSteps   = 24;

  // atan(2^-i) as a 32-bit binary angle
  localparam longint AtanStep [RotSteps] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  logic [15:0] min_mm;
  logic [15:0] max_mm;
  logic [31:0] start_ang;
  logic [31:0] step_ang;

  xy_mm_t xy_due [$];

  function automatic logic signed [16:0] mm_round_sat(input longint v);
    longint r;
    r = (v + RoundHalf) >>> 30;
    if (r > MmLimit) begin
      r = MmLimit;
    end else if (r < -MmLimit) begin
      r = -MmLimit;
    end
    return r[16:0];
  endfunction

  // Window check, beam angle, quadrant fold and CORDIC rotation of one reading.
  function automatic bit beam_to_xy(input logic [15:0] rng, input logic [11:0] idx,
                                    output xy_mm_t res);
    logic [31:0] ang;
    bit          flip;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    int          i;
    res.x = '0;
    res.y = '0;
    if (rng < min_mm || rng > max_mm) return 1'b0;
    if (int'(idx) >= p2cg_pkg::MAX_BEAMS) return 1'b0;
    ang  = start_ang + 32'(idx) * step_ang;
    flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
    if (flip) ang = ang + 32'h8000_0000;
    z = longint'(signed'(ang));
    x = longint'(rng) * CordicGain;
    y = 0;
    for (i = 0; i < RotSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - AtanStep[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + AtanStep[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    res.x = mm_round_sat(x);
    res.y = mm_round_sat(y);
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    xy_mm_t got;
    xy_mm_t want;
    xy_mm_t fresh;
    if (!rst_n) begin
      xy_due.delete();
      min_mm    = 16'd0;
      max_mm    = 16'hFFFF;
      start_ang = '0;
      step_ang  = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.x = out_tdata[16:0];
        got.y = out_tdata[33:17];
        if (xy_due.size() == 0) begin
          if (fail_count < 10)
            $display("[%0t] unexpected result word x=%0d y=%0d", $realtime, got.x, got.y);
          fail_count++;
        end else begin
          want = xy_due.pop_front();
          if (got.x !== want.x || got.y !== want.y) begin
            if (fail_count < 10)
              $display("[%0t] result mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                       $realtime, want.x, want.y, got.x, got.y);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready && beam_to_xy(in_tdata[15:0], in_tdata[27:16], fresh))
        xy_due.insert(xy_due.size(), fresh);
      if (cfg_we) begin
        case (cfg_addr)
          p2cg_pkg::REG_MIN_RANGE:   min_mm    = cfg_wdata[15:0];
          p2cg_pkg::REG_MAX_RANGE:   max_mm    = cfg_wdata[15:0];
          p2cg_pkg::REG_START_ANGLE: start_ang = cfg_wdata;
          p2cg_pkg::REG_ANGLE_STEP:  step_ang  = cfg_wdata;
          default: ;
        endcase
      end
    end
    xy_pending = xy_due.size();
  end

endmodule

FILE: sim/tb_polar_to_cartesian_gate_top.sv
`timescale 1ns / 100ps
// Regression bench for polar_to_cartesian_gate_top: drives beam words and
// register writes, throttles the result side, and reports the verdict.
// Depends on p2cg_pkg, the RTL top and p2cg_xy_checker.

module tb_polar_to_cartesian_gate_top;

  import p2cg_pkg::p2cg_reg_t;
  import p2cg_pkg::REG_MIN_RANGE;
  import p2cg_pkg::REG_MAX_RANGE;
  import p2cg_pkg::REG_START_ANGLE;
  import p2cg_pkg::REG_ANGLE_STEP;

  localparam int RandPhases  = 11;
  localparam int PhaseWords  = 150;
  localparam int SqueezeWords = 200;
  localparam int HoldCycles  = 300;   // result side stall during the squeeze
  localparam int SettleCycles = 40;   // > pipeline latency, covers dropped words

  logic                              clk;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [p2cg_pkg::InDataW-1:0]      in_tdata;   // [15:0] range_mm, [27:16] beam_index
  logic                              out_tvalid;
  logic                              out_tready;
  logic [p2cg_pkg::OutDataW-1:0]     out_tdata;  // [16:0] x_mm, [33:17] y_mm
  logic                              cfg_we;
  logic [1:0]                        cfg_addr;
  logic [p2cg_pkg::AngW-1:0]         cfg_wdata;

  int          fail_count;
  int          xy_pending;
  bit          quiet;       // no idling on either side while set, unless a hold is requested
  bit          sink_hold;   // request one long result-side stall
  logic [15:0] win_lo;
  logic [15:0] win_hi;

  polar_to_cartesian_gate_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  p2cg_xy_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .xy_pending (xy_pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Hard stop; a correct run finishes in a small fraction of this.
  initial begin
    #2_000_000;
    $display("polar_to_cartesian_gate_top regression: fail");
    $finish;
  end

  // Result side: random back-pressure, a long stall on request, or always
  // ready while the quiet stretch runs. The stall is counted here so the
  // sender keeps pushing words into a full pipeline meanwhile.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold) begin
        out_tready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        sink_hold = 1'b0;
      end else if (quiet) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 30);
      end
    end
  end

  // Write one register at a falling edge; hold the strobe for one clock.
  task automatic write_reg(input p2cg_reg_t r, input logic [31:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_window(input logic [15:0] lo, input logic [15:0] hi);
    win_lo = lo;
    win_hi = hi;
    write_reg(REG_MIN_RANGE, {16'd0, lo});
    write_reg(REG_MAX_RANGE, {16'd0, hi});
  endtask

  // Offer one beam word, after a random idle gap, and hold it until taken.
  // Valid stays high into the next word when there is no gap.
  task automatic send_reading(input logic [15:0] rng, input logic [11:0] idx);
    int gap;
    gap = 0;
    while (!quiet && $urandom_range(99) < 30) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, idx, rng};
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid, wait for every expected result, then let dropped words
  // still in the pipeline run out before touching the registers.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (xy_pending == 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Ranges lean on the window edges and just outside them.
  function automatic logic [15:0] pick_range();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return win_lo;
      3: return win_hi;
      4: return win_lo - 16'd1;
      5: return win_hi + 16'd1;
      6: return 16'($urandom);
      default: begin
        if (win_lo <= win_hi) return 16'($urandom_range(win_hi, win_lo));
        return 16'($urandom);
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_start();
    case ($urandom_range(3))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(6))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      4: return $urandom_range(32'h0010_0000);   // up to about one turn per scan
      default: return $urandom;
    endcase
  endfunction

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_MIN_RANGE;
    cfg_wdata = '0;
    quiet     = 1'b0;
    sink_hold = 1'b0;
    win_lo    = 16'd0;
    win_hi    = 16'hFFFF;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: angle zero for every beam, full window.
    send_reading(16'd0, 12'd0);          // zero range inside the window
    send_reading(16'd1, 12'd0);
    send_reading(16'hFFFF, 12'hFFF);     // full range on the x axis, saturates

    // Quarter-turn step walks all four quadrants and the fold.
    settle();
    write_reg(REG_ANGLE_STEP, 32'h4000_0000);
    send_reading(16'hFFFF, 12'd0);
    send_reading(16'hFFFF, 12'd1);
    send_reading(16'hFFFF, 12'd2);
    send_reading(16'hFFFF, 12'd3);
    send_reading(16'd30000, 12'hFFF);
    send_reading(16'd12345, 12'd2);

    // Largest start and step: the angle sum wraps past a full turn.
    settle();
    write_reg(REG_START_ANGLE, 32'h7FFF_FFFF);
    write_reg(REG_ANGLE_STEP, 32'h7FFF_FFFF);
    send_reading(16'd40000, 12'hFFF);
    send_reading(16'd40000, 12'd1);

    // Minimum above maximum: drop everything.
    settle();
    set_window(16'd100, 16'd50);
    send_reading(16'd0, 12'd5);
    send_reading(16'd75, 12'd6);
    send_reading(16'hFFFF, 12'd7);

    // Window edges: one below, both edges, one above.
    settle();
    set_window(16'd1000, 16'd2000);
    send_reading(16'd999, 12'd8);
    send_reading(16'd1000, 12'd9);
    send_reading(16'd2000, 12'd10);
    send_reading(16'd2001, 12'd11);

    // Random phases, each with fresh settings; phase 4 runs without idling.
    for (int ph = 0; ph < RandPhases; ph++) begin
      settle();
      quiet = (ph == 4);
      case (ph)
        0, 10: set_window(16'd0, 16'hFFFF);
        1: set_window(16'hFFFF, 16'hFFFF);
        2: set_window(16'd0, 16'd0);
        3: set_window(16'($urandom_range(65535, 40000)), 16'($urandom_range(30000)));
        default: set_window(16'($urandom_range(3000)), 16'($urandom_range(65535, 30000)));
      endcase
      write_reg(REG_START_ANGLE, pick_start());
      write_reg(REG_ANGLE_STEP, pick_step());
      for (int n = 0; n < PhaseWords; n++)
        send_reading(pick_range(), 12'($urandom_range(4095)));
    end

    // Squeeze: stall the result side for a long stretch while beam words
    // keep coming back to back, so the pipeline fills and in_tready drops.
    settle();
    quiet     = 1'b1;
    sink_hold = 1'b1;
    for (int n = 0; n < SqueezeWords; n++)
      send_reading(pick_range(), 12'($urandom_range(4095)));
    settle();
    quiet = 1'b0;

    if (fail_count == 0) begin
      $display("polar_to_cartesian_gate_top regression: pass");
    end else begin
      $display("polar_to_cartesian_gate_top regression: fail");
    end
    $finish;
  end

endmodule
